>>> design/utf8_stream_decoder_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// same-cycle implication
`define UDEC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8 decoder check failed");

// next-cycle implication
`define UDEC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8 decoder check failed");

`endif

>>> design/udec_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Field widths, lead byte patterns and payload masks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package udec_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 31;
    localparam int OWED_W  = 3;

    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD5_MASK = 8'hFC;
    localparam logic [BYTE_W-1:0] LEAD5_CODE = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD6_MASK = 8'hFE;
    localparam logic [BYTE_W-1:0] LEAD6_CODE = 8'hFC;

    localparam logic [BYTE_W-1:0] PAY_ASCII  = 8'h7F;
    localparam logic [BYTE_W-1:0] PAY_CONT   = 8'h3F;
    localparam logic [BYTE_W-1:0] PAY_LEAD2  = 8'h3F;
    localparam logic [BYTE_W-1:0] PAY_LEAD3  = 8'h0F;
    localparam logic [BYTE_W-1:0] PAY_LEAD4  = 8'h07;
    localparam logic [BYTE_W-1:0] PAY_LEAD5  = 8'h07;
    localparam logic [BYTE_W-1:0] PAY_LEAD6  = 8'h03;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CP_W-1:0]   cp_t;
    typedef logic [OWED_W-1:0] owed_t;

    typedef struct packed {
        cp_t  code_point;
        logic is_end;
        logic bad_lead;
    } result_t;

endpackage

>>> design/udec_if.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder channels
// Valid/ready channels for input bytes and decoded results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface udec_byte_if
    import udec_pkg::*;
;
    logic  valid;
    logic  ready;
    byte_t in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface udec_result_if
    import udec_pkg::*;
;
    logic valid;
    logic ready;
    cp_t  code_point;
    logic is_end;
    logic bad_lead;

    modport source (output valid, output code_point, output is_end, output bad_lead,
                    input ready);
    modport sink   (input valid, input code_point, input is_end, input bad_lead,
                    output ready);
endinterface

>>> design/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes 1-to-6-byte UTF-8 sequences into 31-bit code points.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle and produces at most one result per byte,
// registered, in the cycle after the byte's request is accepted. A result comes
// for an ASCII byte, for the last continuation byte of a sequence, for a zero
// byte (is_end set, any open sequence flushed with zero-filled low bits) and
// for an unrecognized lead byte (code point 0, bad_lead set). Lead and
// continuation bytes that leave bytes still owed produce nothing. The output
// register lets a new byte enter while a result is taken in the same cycle;
// input ready drops only while a result waits and the output is stalled.
`timescale 1ns / 1ps

module utf8_stream_decoder
    import udec_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    udec_byte_if.sink     in_stream,
    udec_result_if.source out_stream
);

    owed_t   owed_reg, owed_next;
    cp_t     acc_reg, acc_next;
    logic    out_valid_reg;
    result_t res_reg, res_next;
    logic    emit;
    logic    accept;
    byte_t   b;
    cp_t     acc_shift;

    assign b         = in_stream.in_byte;
    assign in_stream.ready = !out_valid_reg || out_stream.ready;
    assign accept    = in_stream.valid && in_stream.ready;
    assign acc_shift = {acc_reg[CP_W-7:0], b[5:0] & PAY_CONT[5:0]};

    always_comb
    begin
        owed_next = owed_reg;
        acc_next  = acc_reg;
        emit      = 1'b0;
        res_next  = '0;

        if (b == '0)
        begin
            emit            = 1'b1;
            res_next.is_end = 1'b1;
            owed_next       = '0;
            acc_next        = '0;
            case (owed_reg)
                3'd0:    res_next.code_point = '0;
                3'd1:    res_next.code_point = acc_reg << 6;
                3'd2:    res_next.code_point = acc_reg << 12;
                3'd3:    res_next.code_point = acc_reg << 18;
                3'd4:    res_next.code_point = acc_reg << 24;
                3'd5:    res_next.code_point = acc_reg << 30;
                3'd6:    res_next.code_point = acc_reg << 4;
                3'd7:    res_next.code_point = acc_reg << 10;
                default: res_next.code_point = '0;
            endcase
        end
        else if (owed_reg != '0)
        begin
            owed_next = owed_reg - 3'd1;
            if (owed_reg == 3'd1)
            begin
                emit                = 1'b1;
                res_next.code_point = acc_shift;
                acc_next            = '0;
            end
            else
            begin
                acc_next = acc_shift;
            end
        end
        else if ((b & ASCII_MASK) == '0)
        begin
            emit                = 1'b1;
            res_next.code_point = {{(CP_W-BYTE_W){1'b0}}, b & PAY_ASCII};
        end
        else if ((b & LEAD2_MASK) == LEAD2_CODE)
        begin
            acc_next  = {{(CP_W-BYTE_W){1'b0}}, b & PAY_LEAD2};
            owed_next = 3'd1;
        end
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
        begin
            acc_next  = {{(CP_W-BYTE_W){1'b0}}, b & PAY_LEAD3};
            owed_next = 3'd2;
        end
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
        begin
            acc_next  = {{(CP_W-BYTE_W){1'b0}}, b & PAY_LEAD4};
            owed_next = 3'd3;
        end
        else if ((b & LEAD5_MASK) == LEAD5_CODE)
        begin
            acc_next  = {{(CP_W-BYTE_W){1'b0}}, b & PAY_LEAD5};
            owed_next = 3'd4;
        end
        else if ((b & LEAD6_MASK) == LEAD6_CODE)
        begin
            acc_next  = {{(CP_W-BYTE_W){1'b0}}, b & PAY_LEAD6};
            owed_next = 3'd5;
        end
        else
        begin
            emit              = 1'b1;
            res_next.bad_lead = 1'b1;
            acc_next          = '0;
            owed_next         = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_reg      <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                owed_reg      <= owed_next;
                acc_reg       <= acc_next;
                out_valid_reg <= emit;
            end
            else if (out_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign out_stream.valid      = out_valid_reg;
    assign out_stream.code_point = res_reg.code_point;
    assign out_stream.is_end     = res_reg.is_end;
    assign out_stream.bad_lead   = res_reg.bad_lead;

endmodule

>>> design/udec_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder checker
// Port-level checks on results, bound to the decoder top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_stream_decoder_assert.svh"

module udec_checker
    import udec_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input byte_t in_byte,
    input logic  out_valid,
    input logic  out_ready,
    input cp_t   code_point,
    input logic  is_end,
    input logic  bad_lead
);

    // a zero byte always ends the string with a result
    `UDEC_ASSERT_NEXT(a_zero_ends, in_valid && in_ready && in_byte == '0, out_valid && is_end)

    `UDEC_ASSERT_NOW(a_flags_exclusive, out_valid, !(is_end && bad_lead))

    `UDEC_ASSERT_NOW(a_bad_is_zero, out_valid && bad_lead, code_point == '0)

    // a stalled result holds
    `UDEC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(code_point))

endmodule

bind utf8_stream_decoder udec_checker u_udec_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_stream.valid),
    .in_ready   (in_stream.ready),
    .in_byte    (in_stream.in_byte),
    .out_valid  (out_stream.valid),
    .out_ready  (out_stream.ready),
    .code_point (out_stream.code_point),
    .is_end     (out_stream.is_end),
    .bad_lead   (out_stream.bad_lead)
);

>>> bench/utf8_decode_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder result checker
// Watches both channels, predicts the decoded result for every accepted byte
// request that yields one and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_decode_checker
    import udec_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    udec_byte_if   byte_ch,
    udec_result_if res_ch,
    output int     fail_count,
    output int     pending,
    output int     checked
);

    owed_t   owed;
    cp_t     acc;
    result_t expected_cps[$];
    int      n_fail = 0;
    int      n_checked = 0;

    task automatic report_mismatch(input string msg);
        n_fail++;
        if (n_fail <= 40)
            $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    // Returns 1 when the byte yields a result; updates owed/acc.
    function automatic bit decode_byte(input byte_t b, output result_t r);
        r = '0;
        if (b == '0) begin
            r.code_point = (owed == '0) ? cp_t'(0) : cp_t'(acc << (6 * owed));
            r.is_end     = 1'b1;
            owed         = '0;
            acc          = '0;
            return 1'b1;
        end
        if (owed != '0) begin
            acc  = (acc << 6) | cp_t'(b & PAY_CONT);
            owed = owed - owed_t'(1);
            if (owed == '0) begin
                r.code_point = acc;
                acc          = '0;
                return 1'b1;
            end
            return 1'b0;
        end
        if ((b & ASCII_MASK) == '0) begin
            r.code_point = cp_t'(b & PAY_ASCII);
            return 1'b1;
        end
        if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            acc  = cp_t'(b & PAY_LEAD2);
            owed = owed_t'(1);
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            acc  = cp_t'(b & PAY_LEAD3);
            owed = owed_t'(2);
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            acc  = cp_t'(b & PAY_LEAD4);
            owed = owed_t'(3);
        end else if ((b & LEAD5_MASK) == LEAD5_CODE) begin
            acc  = cp_t'(b & PAY_LEAD5);
            owed = owed_t'(4);
        end else if ((b & LEAD6_MASK) == LEAD6_CODE) begin
            acc  = cp_t'(b & PAY_LEAD6);
            owed = owed_t'(5);
        end else begin
            r.bad_lead = 1'b1;
            acc        = '0;
            owed       = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t fresh;
        result_t want;
        if (!rst_n)
        begin
            owed = '0;
            acc  = '0;
            expected_cps.delete();
            pending <= 0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                if (decode_byte(byte_ch.in_byte, fresh))
                    expected_cps.push_back(fresh);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_cps.size() == 0)
                    report_mismatch($sformatf("unexpected result cp=%h end=%b bad=%b",
                        res_ch.code_point, res_ch.is_end, res_ch.bad_lead));
                else
                begin
                    want = expected_cps.pop_front();
                    n_checked++;
                    if (res_ch.code_point !== want.code_point)
                        report_mismatch($sformatf("code_point got %h want %h",
                            res_ch.code_point, want.code_point));
                    if (res_ch.is_end !== want.is_end)
                        report_mismatch($sformatf("is_end got %b want %b (cp %h)",
                            res_ch.is_end, want.is_end, want.code_point));
                    if (res_ch.bad_lead !== want.bad_lead)
                        report_mismatch($sformatf("bad_lead got %b want %b (cp %h)",
                            res_ch.bad_lead, want.bad_lead, want.code_point));
                end
            end
            pending <= expected_cps.size();
        end
        checked    <= n_checked;
        fail_count <= n_fail;
    end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Drives directed and random byte streams (well-formed sequences of every
// length, truncated sequences, bad leads, noise) with random stalls on both
// channels; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import udec_pkg::*;

    localparam int RANDOM_BYTES = 1200;

    logic clk;
    logic rst_n;
    bit   idle_on = 1'b1;
    int   n_sent = 0;
    int   n_trunc = 0;
    int   seq_count[1:6];
    int   fail_count;
    int   pending;
    int   checked;

    udec_byte_if   byte_ch();
    udec_result_if res_ch();

    utf8_stream_decoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (byte_ch),
        .out_stream (res_ch)
    );

    utf8_decode_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .res_ch     (res_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    task automatic send_byte(input byte_t b);
        n_sent++;
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        @(posedge clk);
        while (byte_ch.ready !== 1'b1)
            @(posedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            byte_ch.valid   <= 1'b0;
            byte_ch.in_byte <= byte_t'($urandom);
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    function automatic byte_t lead_byte(input int len);
        byte_t r;
        r = byte_t'($urandom);
        case (len)
            1:       return byte_t'($urandom_range(1, 127));
            2:       return LEAD2_CODE | (r & ~LEAD2_MASK);
            3:       return LEAD3_CODE | (r & ~LEAD3_MASK);
            4:       return LEAD4_CODE | (r & ~LEAD4_MASK);
            5:       return LEAD5_CODE | (r & ~LEAD5_MASK);
            default: return LEAD6_CODE | (r & ~LEAD6_MASK);
        endcase
    endfunction

    // mostly 10xxxxxx, sometimes any nonzero byte (continuations are unchecked)
    function automatic byte_t cont_byte();
        if ($urandom_range(0, 7) == 0)
            return byte_t'($urandom_range(1, 255));
        return 8'h80 | (byte_t'($urandom) & PAY_CONT);
    endfunction

    // output side stalls
    initial
    begin
        res_ch.ready <= 1'b0;
        @(posedge clk iff rst_n === 1'b1);
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin
        static byte_t dir_bytes[23] = '{
            8'h00, 8'h7F,
            8'hC2, 8'hA9,
            8'hE2, 8'h41, 8'hC3,
            8'hF7, 8'hBF, 8'hBF, 8'hBF,
            8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
            8'h80, 8'hFE, 8'hFF,
            8'hFB, 8'h81, 8'h00
        };
        int n_directed;
        int pick;
        int len;
        int drain;

        foreach (seq_count[i]) seq_count[i] = 0;
        rst_n           <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.in_byte <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_bytes[i])
            send_byte(dir_bytes[i]);
        n_directed = n_sent;

        while (n_sent < n_directed + RANDOM_BYTES)
        begin
            // quiet stretch in the middle and at the end
            idle_on = !((n_sent >= n_directed + 400 && n_sent < n_directed + 600) ||
                        n_sent >= n_directed + RANDOM_BYTES - 200);
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                len = $urandom_range(1, 6);
                send_byte(lead_byte(len));
                repeat (len - 1) send_byte(cont_byte());
                seq_count[len]++;
            end
            else if (pick < 75)
            begin
                len = $urandom_range(2, 6);
                send_byte(lead_byte(len));
                repeat ($urandom_range(0, len - 2)) send_byte(cont_byte());
                send_byte(8'h00);
                n_trunc++;
            end
            else if (pick < 83)
                send_byte(8'h00);
            else if (pick < 92)
                send_byte(byte_t'($urandom));
            else if ($urandom_range(0, 2) == 0)
                send_byte(8'hFE | (byte_t'($urandom) & 8'h01));
            else
                send_byte(8'h80 | (byte_t'($urandom) & PAY_CONT));
        end
        byte_ch.valid <= 1'b0;
        idle_on = 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        drain = 0;
        while (drain < 10)
        begin
            @(posedge clk);
            drain++;
        end

        $display("summary: %0d byte requests (%0d directed), %0d results compared",
                 n_sent, n_directed, checked);
        $display("summary: sequences by length 1..6: %0d %0d %0d %0d %0d %0d, %0d truncated",
                 seq_count[1], seq_count[2], seq_count[3], seq_count[4], seq_count[5],
                 seq_count[6], n_trunc);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout: %0d results still outstanding", pending);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
